@@ hdl/isc_pkg.sv @@
// shared constants, types and helpers for the checkerboard ising sweep core
// no dependencies; compiled before every other file of the block

package isc_pkg;

   // lattice geometry
   localparam int SIDE  = 16;
   localparam int SITES = SIDE * SIDE * SIDE;
   localparam int CW    = $clog2(SIDE);
   localparam int AW    = $clog2(SITES);

   // running spin sum holds -SITES..+SITES
   localparam int SUM_W = $clog2(SITES) + 2;
   localparam logic signed [SUM_W-1:0] SUM_INIT = SUM_W'(-SITES);

   // payload widths
   localparam int RAND_W     = 16;
   localparam int SITE_IDX_W = 12;
   localparam int MAG_W      = 14;

   // threshold registers
   localparam int THR_W     = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_NUM   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int LANES     = CSR_W / THR_W;
   localparam int SLOT_W    = 4;

   // neighbour up count 0..6
   localparam int NBR_W = 3;

   // actions
   localparam logic ACT_UPDATE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   // read sequence: own spin, then the six wrapped neighbours
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_SELF = 3'd0;
   localparam logic [STEP_W-1:0] STEP_IP   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_IM   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_JP   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_JM   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_KP   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_KM   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GATHER,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic restart;
      logic advance;
   } walk_ctrl_type;

   typedef struct packed {
      logic [AW-1:0] site_addr;
      logic [AW-1:0] rd_addr;
      logic          sweep_end;
   } walk_status_type;

   // linear site index i*SIDE*SIDE + j*SIDE + k
   function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] ci,
                                               input logic [CW-1:0] cj,
                                               input logic [CW-1:0] ck);
      return AW'(ci) * AW'(SIDE * SIDE) + AW'(cj) * AW'(SIDE) + AW'(ck);
   endfunction

endpackage

@@ hdl/isc_req_if.sv @@
// request channel: action and random value with valid/ready
// depends on isc_pkg

interface isc_req_if import isc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [RAND_W-1:0] rand_value;

   modport source (output valid, output action, output rand_value, input ready);
   modport sink (input valid, input action, input rand_value, output ready);
endinterface

@@ hdl/isc_rsp_if.sv @@
// response channel: per-item update result with valid/ready
// depends on isc_pkg

interface isc_rsp_if import isc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    flipped;
   logic [SITE_IDX_W-1:0]   site_index;
   logic signed [MAG_W-1:0] magnetization;
   logic                    sweep_done;

   modport source (output valid, output flipped, output site_index, output magnetization,
                   output sweep_done, input ready);
   modport sink (input valid, input flipped, input site_index, input magnetization,
                 input sweep_done, output ready);
endinterface

@@ hdl/isc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module isc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/isc_site_walk.sv @@
// checkerboard site cursor and neighbour address generator
// depends on isc_pkg

module isc_site_walk import isc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  walk_ctrl_type     ctrl,
   input  logic [STEP_W-1:0] rd_step,
   output walk_status_type   status
);

   logic [CW-1:0] ci_ff, ci_in;
   logic [CW-1:0] cj_ff, cj_in;
   logic [CW-1:0] ck_ff, ck_in;
   logic          parity_ff, parity_in;

   logic [CW:0]   k_two;
   logic          row_end;
   logic          pass_end;
   logic [CW-1:0] row_i;
   logic [CW-1:0] row_j;
   logic          row_par;
   logic [CW-1:0] i_up, i_dn, j_up, j_dn, k_up, k_dn;
   logic [CW-1:0] ri, rj, rk;

   // end of row and end of pass detection
   assign k_two    = {1'b0, ck_ff} + (CW+1)'(2);
   assign row_end  = k_two >= (CW+1)'(SIDE);
   assign pass_end = row_end && (ci_ff == CW'(SIDE - 1)) && (cj_ff == CW'(SIDE - 1));

   // next row coordinates inside the current pass
   always_comb begin
      row_i = ci_ff;
      row_j = cj_ff + CW'(1);
      if (cj_ff == CW'(SIDE - 1)) begin
         row_j = '0;
         row_i = ci_ff + CW'(1);
      end
   end

   assign row_par = parity_ff ^ row_i[0] ^ row_j[0];

   // cursor advance, pass change and restart
   always_comb begin
      ci_in     = ci_ff;
      cj_in     = cj_ff;
      ck_in     = ck_ff;
      parity_in = parity_ff;
      if (ctrl.restart) begin
         ci_in     = '0;
         cj_in     = '0;
         ck_in     = '0;
         parity_in = 1'b0;
      end else if (ctrl.advance) begin
         if (!row_end) begin
            ck_in = k_two[CW-1:0];
         end else if (!pass_end) begin
            ci_in = row_i;
            cj_in = row_j;
            ck_in = CW'(row_par);
         end else begin
            // other parity starts at (0,0,new parity)
            ci_in     = '0;
            cj_in     = '0;
            ck_in     = CW'(!parity_ff);
            parity_in = ~parity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff     <= '0;
         cj_ff     <= '0;
         ck_ff     <= '0;
         parity_ff <= 1'b0;
      end else begin
         ci_ff     <= ci_in;
         cj_ff     <= cj_in;
         ck_ff     <= ck_in;
         parity_ff <= parity_in;
      end
   end

   // periodic neighbour coordinates
   assign i_up = (ci_ff == CW'(SIDE - 1)) ? '0 : ci_ff + CW'(1);
   assign i_dn = (ci_ff == '0) ? CW'(SIDE - 1) : ci_ff - CW'(1);
   assign j_up = (cj_ff == CW'(SIDE - 1)) ? '0 : cj_ff + CW'(1);
   assign j_dn = (cj_ff == '0) ? CW'(SIDE - 1) : cj_ff - CW'(1);
   assign k_up = (ck_ff == CW'(SIDE - 1)) ? '0 : ck_ff + CW'(1);
   assign k_dn = (ck_ff == '0) ? CW'(SIDE - 1) : ck_ff - CW'(1);

   // read address for the current step of the sequence
   always_comb begin
      ri = ci_ff;
      rj = cj_ff;
      rk = ck_ff;
      case (rd_step)
         STEP_IP: ri = i_up;
         STEP_IM: ri = i_dn;
         STEP_JP: rj = j_up;
         STEP_JM: rj = j_dn;
         STEP_KP: rk = k_up;
         STEP_KM: rk = k_dn;
         default: ri = ci_ff;
      endcase
   end

   assign status.site_addr = site_addr(ci_ff, cj_ff, ck_ff);
   assign status.rd_addr   = site_addr(ri, rj, rk);
   assign status.sweep_end = pass_end && parity_ff;

endmodule

@@ hdl/ising_checkerboard_metropolis_sweep_core.sv @@
// update item: the result follows the request transfer after a gather phase (own spin and six
// neighbours through one ram read port) and a decide/write-back state that waits for a free
// result register; one item at a time, a new request is taken only in idle
// restart item: a clearing pass writes every spin down, one entry per cycle, then reports
// reset: synchronous; thresholds clear to 0 and a clearing pass of every site precedes the first
// request transfer; depends on isc_pkg, isc_req_if, isc_rsp_if, isc_ram and isc_site_walk

module ising_checkerboard_metropolis_sweep_core import isc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   isc_req_if.sink              req,
   isc_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic [STEP_W-1:0]       step_ff, step_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic                    report_ff, report_in;
   logic                    own_up_ff, own_up_in;
   logic [NBR_W-1:0]        nup_ff, nup_in;
   logic [RAND_W-1:0]       rand_ff, rand_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic [CSR_NUM-1:0][LANES-1:0][THR_W-1:0] thr_ff, thr_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    flipped_ff, flipped_in;
   logic [SITE_IDX_W-1:0]   site_idx_ff, site_idx_in;
   logic signed [MAG_W-1:0] mag_ff, mag_in;
   logic                    done_ff, done_in;

   logic              req_fire;
   logic              out_free;
   logic              out_load;
   logic              clear_last;
   logic [SLOT_W-1:0] slot;
   logic [THR_W-1:0]  thr;
   logic              flip;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [0:0]        mem_wdata;
   logic [0:0]        mem_rdata;
   logic [STEP_W-1:0] rd_step;
   walk_ctrl_type     walk_ctrl;
   walk_status_type   walk_status;

   // handshake terms
   assign req_fire   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign clear_last = clr_addr_ff == AW'(SITES - 1);

   // acceptance test: slot from own spin and neighbour up count
   assign slot = own_up_ff ? SLOT_W'(7) + SLOT_W'(nup_ff) : SLOT_W'(nup_ff);
   assign thr  = thr_ff[slot[SLOT_W-1:2]][slot[1:0]];
   assign flip = rand_ff <= thr;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = report_ff ? ST_DECIDE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req.action == ACT_RESTART) ? ST_CLEAR : ST_GATHER;
            end
         end
         ST_GATHER: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control outputs; the spin store is written only in clear and decide, reads of the next item
   // start in the cycle after decide, and the read data of clear and decide is never used
   always_comb begin
      req.ready         = 1'b0;
      out_load          = 1'b0;
      mem_we            = 1'b0;
      mem_waddr         = walk_status.site_addr;
      mem_wdata         = ~own_up_ff;
      rd_step           = STEP_SELF;
      walk_ctrl.restart = 1'b0;
      walk_ctrl.advance = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = 1'b0;
         end
         ST_IDLE: begin
            req.ready         = 1'b1;
            walk_ctrl.restart = req_fire && (req.action == ACT_RESTART);
         end
         ST_GATHER: begin
            rd_step = step_ff;
         end
         ST_DECIDE: begin
            out_load          = out_free;
            mem_we            = out_free && !report_ff && flip;
            walk_ctrl.advance = out_free && !report_ff;
         end
         default: req.ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      step_in     = step_ff;
      clr_addr_in = clr_addr_ff;
      report_in   = report_ff;
      own_up_in   = own_up_ff;
      nup_in      = nup_ff;
      rand_in     = rand_ff;
      sum_in      = sum_ff;
      thr_in      = thr_ff;

      if (csr_we) begin
         thr_in[csr_index] = csr_wdata;
      end

      // item intake
      if (req_fire) begin
         rand_in = req.rand_value;
         step_in = STEP_IP;
         nup_in  = '0;
         if (req.action == ACT_RESTART) begin
            clr_addr_in = '0;
            report_in   = 1'b1;
            sum_in      = SUM_INIT;
         end
      end

      // clearing pass
      if (state_ff == ST_CLEAR) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      // ram read data is registered, so each step takes the data of the previous step's address
      if (state_ff == ST_GATHER) begin
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_IP) begin
            own_up_in = mem_rdata[0];
         end else begin
            nup_in = nup_ff + NBR_W'(mem_rdata[0]);
         end
      end

      // write-back of the spin sum
      if (out_load) begin
         report_in = 1'b0;
         if (!report_ff && flip) begin
            sum_in = own_up_ff ? sum_ff - SUM_W'(2) : sum_ff + SUM_W'(2);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      flipped_in   = flipped_ff;
      site_idx_in  = site_idx_ff;
      mag_in       = mag_ff;
      done_in      = done_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         flipped_in   = !report_ff && flip;
         site_idx_in  = report_ff ? '0 : SITE_IDX_W'(walk_status.site_addr);
         mag_in       = MAG_W'(sum_in);
         done_in      = !report_ff && walk_status.sweep_end;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         report_ff    <= 1'b0;
         step_ff      <= STEP_SELF;
         sum_ff       <= SUM_INIT;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         report_ff    <= report_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      own_up_ff   <= own_up_in;
      nup_ff      <= nup_in;
      rand_ff     <= rand_in;
      flipped_ff  <= flipped_in;
      site_idx_ff <= site_idx_in;
      mag_ff      <= mag_in;
      done_ff     <= done_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.flipped       = flipped_ff;
   assign rsp.site_index    = site_idx_ff;
   assign rsp.magnetization = mag_ff;
   assign rsp.sweep_done    = done_ff;

   // spin store, one bit per site, 1 = spin up
   isc_ram #(
      .WIDTH (1),
      .DEPTH (SITES)
   ) u_spin_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (walk_status.rd_addr),
      .rd_data (mem_rdata)
   );

   // checkerboard cursor
   isc_site_walk u_site_walk (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (walk_ctrl),
      .rd_step (rd_step),
      .status  (walk_status)
   );

`ifndef SYNTHESIS
   a_ram_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_DECIDE))
      else $error("spin store written outside clear or decide");

   a_clear_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (sum_ff == SUM_INIT))
      else $error("spin sum not at all-down value during clearing pass");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (sum_ff >= SUM_INIT) && (sum_ff <= -SUM_INIT))
      else $error("spin sum out of lattice range");

   a_flip_step: assert property (@(posedge clock) disable iff (reset)
      (out_load && !report_ff && flip) |=>
      ((sum_ff == $past(sum_ff) + SUM_W'(2)) || (sum_ff == $past(sum_ff) - SUM_W'(2))))
      else $error("flip did not move spin sum by two");
`endif

endmodule
